FILE: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define DGF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("dgf assertion failed");

// property checked on every edge, reset included
`define DGF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dgf assertion failed");

`endif

FILE: hdl/dgf_pkg.sv
package dgf_pkg;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_CORR  = 1'b1;

    localparam logic [47:0] RES_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic              command;
        logic [3:0]        slot;
        logic [3:0]        map_index;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
        logic signed [31:0] pinv_x;
        logic signed [31:0] pinv_y;
        logic signed [31:0] pinv_z;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic signed [39:0] f_xx;
        logic signed [39:0] f_xy;
        logic signed [39:0] f_xz;
        logic signed [39:0] f_yx;
        logic signed [39:0] f_yy;
        logic signed [39:0] f_yz;
        logic signed [39:0] f_zx;
        logic signed [39:0] f_zy;
        logic signed [39:0] f_zz;
        logic [47:0]        res_x;
        logic [47:0]        res_y;
        logic [47:0]        res_z;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_M,
        S_ACC,
        S_RES_ID,
        S_RES_M,
        S_RES_MC,
        S_FID,
        S_DIFF,
        S_SQ,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_ADD,
        M_FIN
    } t_mac_state;

    // rounding point: accumulate >>24, f*ideal >>28, square >>32
    typedef enum logic [1:0] {
        MODE_ACC,
        MODE_FID,
        MODE_SQ
    } t_mac_mode;

    typedef struct packed {
        logic      go;
        t_mac_mode mode;
    } t_mac_req;

    function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
        logic signed [39:0] r;
        if ((&x[63:39]) || !(|x[63:39])) begin
            r = x[39:0];
        end else if (x[63]) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = 40'sh7F_FFFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: hdl/dgf_if.sv
interface dgf_in_if;
    logic              valid;
    logic              ready;
    dgf_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dgf_out_if;
    logic               valid;
    logic               ready;
    dgf_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/dgf_ram.sv
module dgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/dgf_mac.sv
module dgf_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dgf_pkg::t_mac_req   i_req,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic                o_done,
    output logic signed [63:0]  o_res
);

    dgf_pkg::t_mac_state r_state, n_state;
    dgf_pkg::t_mac_mode  r_mode;
    logic                r_neg;
    logic [47:0]         r_ua, r_ub;
    logic [1:0]          r_q;
    logic [63:0]         r_prod;
    logic [95:0]         r_pacc;
    logic                r_done;
    logic signed [63:0]  r_res;

    logic        w_load, w_mul, w_add, w_fin;
    logic        w_last;
    logic [1:0]  w_qnext;
    logic [31:0] w_pa, w_pb;
    logic [95:0] w_shifted, w_rsum;
    logic [63:0] w_rnd;
    logic [63:0] w_abs_a, w_abs_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgf_pkg::M_IDLE: if (i_req.go) n_state = dgf_pkg::M_MUL;
            dgf_pkg::M_MUL:  n_state = dgf_pkg::M_ADD;
            dgf_pkg::M_ADD:  n_state = w_last ? dgf_pkg::M_FIN : dgf_pkg::M_MUL;
            dgf_pkg::M_FIN:  n_state = dgf_pkg::M_IDLE;
            default:         n_state = dgf_pkg::M_IDLE;
        endcase
    end

    always_comb begin
        w_load = 1'b0;
        w_mul  = 1'b0;
        w_add  = 1'b0;
        w_fin  = 1'b0;
        unique case (r_state)
            dgf_pkg::M_IDLE: w_load = i_req.go;
            dgf_pkg::M_MUL:  w_mul  = 1'b1;
            dgf_pkg::M_ADD:  w_add  = 1'b1;
            dgf_pkg::M_FIN:  w_fin  = 1'b1;
            default:         w_load = 1'b0;
        endcase
    end

    assign w_abs_a = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_abs_b = i_b[63] ? 64'(-i_b) : 64'(i_b);

    // partial index: bit 1 picks the upper half of a, bit 0 of b
    assign w_pa = r_q[1] ? {16'b0, r_ua[47:32]} : r_ua[31:0];
    assign w_pb = r_q[0] ? {16'b0, r_ub[47:32]} : r_ub[31:0];

    always_comb begin
        unique case (r_q)
            2'd0:    w_shifted = {32'b0, r_prod};
            2'd1:    w_shifted = {r_prod, 32'b0};
            2'd2:    w_shifted = {r_prod, 32'b0};
            2'd3:    w_shifted = {r_prod[31:0], 64'b0};
            default: w_shifted = {32'b0, r_prod};
        endcase
    end

    always_comb begin
        priority case (r_mode)
            dgf_pkg::MODE_ACC: begin
                w_last  = 1'b1;
                w_qnext = r_q + 2'd1;
            end
            dgf_pkg::MODE_FID: begin
                // upper half of b is always zero here
                w_last  = (r_q == 2'd2);
                w_qnext = 2'd2;
            end
            default: begin
                w_last  = (r_q == 2'd3);
                w_qnext = r_q + 2'd1;
            end
        endcase
    end

    always_comb begin
        priority case (r_mode)
            dgf_pkg::MODE_ACC: begin
                w_rsum = r_pacc + (96'd1 << 23);
                w_rnd  = w_rsum[87:24];
            end
            dgf_pkg::MODE_FID: begin
                w_rsum = r_pacc + (96'd1 << 27);
                w_rnd  = w_rsum[91:28];
            end
            default: begin
                w_rsum = r_pacc + (96'd1 << 31);
                w_rnd  = w_rsum[95:32];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgf_pkg::M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ua   <= w_abs_a[47:0];
            r_ub   <= w_abs_b[47:0];
            r_neg  <= i_a[63] ^ i_b[63];
            r_mode <= i_req.mode;
            r_q    <= 2'd0;
            r_pacc <= '0;
        end
        if (w_mul) begin
            r_prod <= w_pa * w_pb;
        end
        if (w_add) begin
            r_pacc <= r_pacc + w_shifted;
            r_q    <= w_qnext;
        end
        if (w_fin) begin
            r_res <= r_neg ? -$signed(w_rnd) : $signed(w_rnd);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hdl/deformation_gradient_fit_top.sv
// channel  dir  beat
// i_in     in   command, slot, map_index, val_x/y/z, pinv_x/y/z, last
// o_out    out  f_xx..f_zz (Q8.32 sat), res_x/y/z (Q16.32 sat)
//
// store (command 0): taken while idle, ready again at once
// correspondence (store not full): nine products through the shared 32x32 multiplier
// last correspondence: plus a residual pass over every stored entry
// reset clears gradient sums and entry count; point stores hold garbage until written
// o_out holds its beat until taken; i_in is not ready while a result waits
module deformation_gradient_fit_top #(
    parameter int MAX_POINTS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    dgf_in_if.sink    i_in,
    dgf_out_if.source o_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    dgf_pkg::t_state r_state, n_state;

    logic [CW-1:0]      r_cnt, r_k;
    logic [1:0]         r_i, r_j;
    logic               r_wait, r_last, r_mz;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_m [3];
    logic signed [31:0] r_id [3];
    logic signed [63:0] r_g [9];
    logic signed [63:0] r_racc, r_d;
    logic [47:0]        r_res [3];

    logic               w_in_acc, w_out_acc, w_cnt_free;
    logic               w_ms_we, w_id_we;
    logic [AW-1:0]      w_ms_raddr;
    logic [95:0]        w_ms_rdata;
    logic [99:0]        w_id_rdata;
    logic [3:0]         w_gi;
    logic [3:0]         w_match;
    dgf_pkg::t_mac_req  w_req;
    logic signed [63:0] w_a, w_b, w_mac_res;
    logic               w_done;
    logic [47:0]        w_sq;
    logic [48:0]        w_rsum;
    logic [CW-1:0]      w_k_next;
    dgf_pkg::t_out_item w_out;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_cnt_free = (r_cnt < CW'(MAX_POINTS));
    assign w_gi       = {1'b0, r_i, 1'b0} + {2'b0, r_i} + {2'b0, r_j};
    assign w_match    = w_id_rdata[99:96];
    assign w_k_next   = r_k + CW'(1);

    assign w_ms_we = w_in_acc && (i_in.data.command == dgf_pkg::CMD_STORE)
                     && (32'(i_in.data.slot) < MAX_POINTS);
    assign w_id_we = w_in_acc && (i_in.data.command == dgf_pkg::CMD_CORR) && w_cnt_free;

    dgf_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_meas (
        .i_clk   (i_clk),
        .i_we    (w_ms_we),
        .i_waddr (AW'(i_in.data.slot)),
        .i_wdata ({i_in.data.val_z, i_in.data.val_y, i_in.data.val_x}),
        .i_raddr (w_ms_raddr),
        .o_rdata (w_ms_rdata)
    );

    dgf_ram #(.WIDTH(100), .DEPTH(MAX_POINTS)) u_ideal (
        .i_clk   (i_clk),
        .i_we    (w_id_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_in.data.map_index, i_in.data.val_z, i_in.data.val_y, i_in.data.val_x}),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_id_rdata)
    );

    dgf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_mac_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgf_pkg::S_IDLE: begin
                if (w_in_acc && i_in.data.command == dgf_pkg::CMD_CORR) begin
                    if (w_cnt_free) begin
                        n_state = dgf_pkg::S_ACC_M;
                    end else if (i_in.data.last) begin
                        // store full, still run the residual pass
                        n_state = (r_cnt == '0) ? dgf_pkg::S_OUT : dgf_pkg::S_RES_ID;
                    end
                end
            end
            dgf_pkg::S_ACC_M: n_state = dgf_pkg::S_ACC;
            dgf_pkg::S_ACC: begin
                if (w_done && r_i == 2'd2 && r_j == 2'd2) begin
                    n_state = r_last ? dgf_pkg::S_RES_ID : dgf_pkg::S_IDLE;
                end
            end
            dgf_pkg::S_RES_ID: n_state = dgf_pkg::S_RES_M;
            dgf_pkg::S_RES_M:  n_state = dgf_pkg::S_RES_MC;
            dgf_pkg::S_RES_MC: n_state = dgf_pkg::S_FID;
            dgf_pkg::S_FID: begin
                if (w_done && r_j == 2'd2) n_state = dgf_pkg::S_DIFF;
            end
            dgf_pkg::S_DIFF: n_state = dgf_pkg::S_SQ;
            dgf_pkg::S_SQ: begin
                if (w_done) begin
                    if (r_i != 2'd2) begin
                        n_state = dgf_pkg::S_FID;
                    end else if (w_k_next == r_cnt) begin
                        n_state = dgf_pkg::S_OUT;
                    end else begin
                        n_state = dgf_pkg::S_RES_ID;
                    end
                end
            end
            dgf_pkg::S_OUT: if (w_out_acc) n_state = dgf_pkg::S_IDLE;
            default: n_state = dgf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_req.go   = 1'b0;
        w_req.mode = dgf_pkg::MODE_ACC;
        w_a        = '0;
        w_b        = '0;
        w_ms_raddr = AW'(i_in.data.map_index);
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            dgf_pkg::S_IDLE: i_in.ready = 1'b1;
            dgf_pkg::S_ACC: begin
                w_req.go   = !r_wait;
                w_req.mode = dgf_pkg::MODE_ACC;
                w_a        = 64'(r_p[r_j]);
                w_b        = 64'(r_m[r_i]);
            end
            dgf_pkg::S_RES_M: w_ms_raddr = AW'(w_match);
            dgf_pkg::S_FID: begin
                w_req.go   = !r_wait;
                w_req.mode = dgf_pkg::MODE_FID;
                w_a        = 64'(dgf_pkg::sat40(r_g[w_gi]));
                w_b        = 64'(r_id[r_j]);
            end
            dgf_pkg::S_SQ: begin
                w_req.go   = !r_wait;
                w_req.mode = dgf_pkg::MODE_SQ;
                w_a        = r_d;
                w_b        = r_d;
            end
            dgf_pkg::S_OUT: o_out.valid = 1'b1;
            default: w_req.go = 1'b0;
        endcase
    end

    // square is never negative
    assign w_sq   = (|w_mac_res[63:48]) ? dgf_pkg::RES_MAX : w_mac_res[47:0];
    assign w_rsum = {1'b0, r_res[r_i]} + {1'b0, w_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgf_pkg::S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_wait  <= 1'b0;
            for (int n = 0; n < 9; n++) r_g[n] <= '0;
            for (int n = 0; n < 3; n++) r_res[n] <= '0;
        end else begin
            r_state <= n_state;
            if (w_req.go) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            if (r_state == dgf_pkg::S_IDLE) begin
                r_k <= '0;
                if (w_id_we) r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == dgf_pkg::S_ACC && w_done) begin
                r_g[w_gi] <= r_g[w_gi] + w_mac_res;
            end
            if (r_state == dgf_pkg::S_SQ && w_done) begin
                r_res[r_i] <= w_rsum[48] ? dgf_pkg::RES_MAX : w_rsum[47:0];
                if (r_i == 2'd2) r_k <= w_k_next;
            end
            if (w_out_acc) begin
                r_cnt <= '0;
                for (int n = 0; n < 9; n++) r_g[n] <= '0;
                for (int n = 0; n < 3; n++) r_res[n] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dgf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_p[0] <= i_in.data.pinv_x;
                    r_p[1] <= i_in.data.pinv_y;
                    r_p[2] <= i_in.data.pinv_z;
                    r_last <= i_in.data.last;
                    r_mz   <= (32'(i_in.data.map_index) >= MAX_POINTS);
                end
            end
            dgf_pkg::S_ACC_M, dgf_pkg::S_RES_MC: begin
                r_m[0] <= r_mz ? 32'sd0 : w_ms_rdata[31:0];
                r_m[1] <= r_mz ? 32'sd0 : w_ms_rdata[63:32];
                r_m[2] <= r_mz ? 32'sd0 : w_ms_rdata[95:64];
                r_i    <= 2'd0;
                r_j    <= 2'd0;
            end
            dgf_pkg::S_ACC: begin
                if (w_done) begin
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            dgf_pkg::S_RES_M: begin
                r_id[0] <= w_id_rdata[31:0];
                r_id[1] <= w_id_rdata[63:32];
                r_id[2] <= w_id_rdata[95:64];
                r_mz    <= (32'(w_match) >= MAX_POINTS);
            end
            dgf_pkg::S_FID: begin
                if (w_done) begin
                    r_racc <= (r_j == 2'd0) ? w_mac_res : r_racc + w_mac_res;
                    r_j    <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                end
            end
            dgf_pkg::S_DIFF: begin
                r_d <= r_racc - (64'(r_m[r_i]) <<< 4);
            end
            dgf_pkg::S_SQ: begin
                if (w_done) r_i <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
            end
            default: r_d <= r_d;
        endcase
    end

    always_comb begin
        w_out.f_xx  = dgf_pkg::sat40(r_g[0]);
        w_out.f_xy  = dgf_pkg::sat40(r_g[1]);
        w_out.f_xz  = dgf_pkg::sat40(r_g[2]);
        w_out.f_yx  = dgf_pkg::sat40(r_g[3]);
        w_out.f_yy  = dgf_pkg::sat40(r_g[4]);
        w_out.f_yz  = dgf_pkg::sat40(r_g[5]);
        w_out.f_zx  = dgf_pkg::sat40(r_g[6]);
        w_out.f_zy  = dgf_pkg::sat40(r_g[7]);
        w_out.f_zz  = dgf_pkg::sat40(r_g[8]);
        w_out.res_x = r_res[0];
        w_out.res_y = r_res[1];
        w_out.res_z = r_res[2];
    end

    assign o_out.data = w_out;

endmodule

FILE: hdl/dgf_checker.sv
`include "assert_macros.svh"

module dgf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_cmd,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input dgf_pkg::t_out_item i_out_data
);

    logic w_store_beat;

    assign w_store_beat = i_in_valid && i_in_ready && (i_in_cmd == dgf_pkg::CMD_STORE);

    `DGF_ASSERT(a_busy_while_result, i_clk, i_rst_n, i_out_valid |-> !i_in_ready)
    `DGF_ASSERT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n |=> !i_out_valid)
    `DGF_ASSERT(a_store_no_result, i_clk, i_rst_n, w_store_beat |=> !i_out_valid)
    `DGF_ASSERT(a_result_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> $stable(i_out_data))

endmodule

bind deformation_gradient_fit_top dgf_checker u_dgf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.data.command),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
